>>> design/ir_vote_byte_decoder_assert.svh
// ----------------------------------------------------------------------------
// ir vote byte decoder assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef IR_VOTE_BYTE_DECODER_ASSERT_SVH
`define IR_VOTE_BYTE_DECODER_ASSERT_SVH

// same-cycle implication, quiet while reset is asserted
`define IRVB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("irvb assertion failed");

// next-cycle implication, quiet while reset is asserted
`define IRVB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("irvb assertion failed");

`endif

>>> design/irvb_pkg.sv
// ----------------------------------------------------------------------------
// irvb_pkg
// constants and types shared by the ir vote byte decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irvb_pkg;

	localparam logic [5:0]  LEAD_TICK    = 6'd5;
	localparam logic [5:0]  BIT_TICK     = 6'd25;
	localparam logic [5:0]  TAIL_TICK    = 6'd32;
	localparam logic [5:0]  GAP_FIRST    = 6'd33;
	localparam logic [5:0]  TIMEOUT_TICK = 6'd37;
	localparam logic [7:0]  LAST_MASK    = 8'h80;
	localparam logic [15:0] HOLD_RESET   = 16'd3000;
	localparam logic [15:0] AGE_MAX      = 16'hFFFF;

	// one decoded result per sample
	typedef struct packed {
		logic       carrier_present;
		logic       receiving;
		logic [7:0] data_byte;
		logic       byte_ready;
	} irvb_result_t;

	// plain sampling ticks where a high is only counted
	function automatic logic is_sample_tick(input logic [5:0] t);
		logic hit;
		case (t)
			6'd1, 6'd3, 6'd9, 6'd11, 6'd17, 6'd21, 6'd30, 6'd31: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

`default_nettype wire

>>> design/ir_vote_byte_decoder.sv
// ----------------------------------------------------------------------------
// ir_vote_byte_decoder
// majority-vote infrared byte receiver, one pin sample per item
// ----------------------------------------------------------------------------
// channel   dir  tdata bits (low first)
// s_axis    in   [0] pin_level, [7:1] zero
// m_axis    out  [0] byte_ready, [8:1] data_byte, [9] receiving,
//                [10] carrier_present, [15:11] zero
// cfg       in   cfg_wdata = presence_hold, written when cfg_we is high
//
// one item per cycle sustained while the output is not stalled; each item
// passes through the input register and then the result register
// the decoder state advances only when an item moves into the result register
// a stalled output holds its item and the input register backs up behind it
// reset clears all control state and loads presence_hold with 3000
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ir_vote_byte_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [0] pin_level
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata    // [0] byte_ready, [8:1] data_byte,
	                                         // [9] receiving, [10] carrier_present
);
	import irvb_pkg::*;

	logic         valid_s1;
	logic         pin_s1;
	logic         advance;
	logic         out_valid_q;
	irvb_result_t out_q;
	irvb_result_t step_res;

	// item moves on when the result register is empty or being drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pin_s1 <= s_axis_tdata[0];
		end
	end

	irvb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step_en   (advance),
		.pin_level (pin_s1),
		.result    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= step_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, out_q};

endmodule

`default_nettype wire

>>> design/irvb_core.sv
// ----------------------------------------------------------------------------
// irvb_core
// frame timing, majority votes, byte assembly and presence hold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irvb_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [15:0]          cfg_wdata,
	input  wire logic                 step_en,
	input  wire logic                 pin_level,
	output irvb_pkg::irvb_result_t    result
);
	import irvb_pkg::*;

	logic        active_q, active_d;
	logic [5:0]  elapsed_q, elapsed_d;
	logic [2:0]  vote_q, vote_d;
	logic [7:0]  mask_q, mask_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  last_q, last_d;
	logic        present_q, present_d;
	logic [15:0] age_q, age_d;
	logic [15:0] hold_q;
	logic        done;
	logic [5:0]  t;
	logic [2:0]  vsum;

	assign t    = elapsed_q + 6'd1;
	assign vsum = vote_q + {2'b00, pin_level};

	always_comb begin
		active_d = active_q;
		elapsed_d = elapsed_q;
		vote_d = vote_q;
		mask_d = mask_q;
		shift_d = shift_q;
		last_d = last_q;
		done = 1'b0;
		if (!active_q) begin
			if (!pin_level) begin
				active_d = 1'b1;
				elapsed_d = '0;
				mask_d = 8'h01;
				vote_d = '0;
			end
		end else begin
			elapsed_d = t;
			if (t > TIMEOUT_TICK) begin
				active_d = 1'b0;
			end else if (is_sample_tick(t)) begin
				vote_d = vsum;
			end else if (t == LEAD_TICK) begin
				if (vsum > 3'd1) begin
					active_d = 1'b0;
				end
				vote_d = '0;
			end else if (t == BIT_TICK) begin
				if (vsum > 3'd3) begin
					shift_d = shift_q | mask_q;
				end else if (vsum < 3'd2) begin
					shift_d = shift_q & ~mask_q;
				end else begin
					active_d = 1'b0;
				end
				vote_d = '0;
			end else if (t == TAIL_TICK) begin
				if (vsum < 3'd2) begin
					active_d = 1'b0;
				end else if (mask_q == LAST_MASK) begin
					mask_d = 8'h01;
					active_d = 1'b0;
					last_d = shift_q;
					done = 1'b1;
				end
				vote_d = '0;
			end else if (t >= GAP_FIRST) begin
				// low in the gap window opens the next bit
				if (!pin_level) begin
					mask_d = {mask_q[6:0], 1'b0};
					elapsed_d = '0;
				end
			end
		end
	end

	always_comb begin
		present_d = present_q;
		age_d = age_q;
		if (done) begin
			present_d = 1'b1;
			age_d = '0;
		end else if (present_q) begin
			if (age_q >= hold_q) begin
				present_d = 1'b0;
			end else if (age_q < AGE_MAX) begin
				age_d = age_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (cfg_we) begin
			hold_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			elapsed_q <= '0;
			vote_q <= '0;
			mask_q <= '0;
			shift_q <= '0;
			last_q <= '0;
			present_q <= 1'b0;
			age_q <= '0;
		end else if (step_en) begin
			active_q <= active_d;
			elapsed_q <= elapsed_d;
			vote_q <= vote_d;
			mask_q <= mask_d;
			shift_q <= shift_d;
			last_q <= last_d;
			present_q <= present_d;
			age_q <= age_d;
		end
	end

	assign result.byte_ready      = done;
	assign result.data_byte       = last_d;
	assign result.receiving       = active_d;
	assign result.carrier_present = present_d;

endmodule

`default_nettype wire

>>> design/irvb_check.sv
// ----------------------------------------------------------------------------
// irvb_check
// port-level checks on the ir vote byte decoder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ir_vote_byte_decoder_assert.svh"

module irvb_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);

	// a completed byte always raises presence on the same item
	`IRVB_ASSERT_IMP(a_ready_sets_present, clk, arst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[10])

	// a completed byte closes the frame
	`IRVB_ASSERT_IMP(a_ready_ends_frame, clk, arst_n, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[9])

	// padding bits stay zero
	`IRVB_ASSERT_IMP(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[15:11] == 5'b00000)

	// a stalled item holds
	`IRVB_ASSERT_NXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind ir_vote_byte_decoder irvb_check u_irvb_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
